### rtl/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
// Used by jsu_front, jsu_fifo, jsu_back and json_string_unescape_utf8_core.
package jsu_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_NO_QUOTE = 3'd1;
    localparam logic [2:0] CAUSE_CONTROL  = 3'd2;
    localparam logic [2:0] CAUSE_ESCAPE   = 3'd3;
    localparam logic [2:0] CAUSE_HEX      = 3'd4;
    localparam logic [2:0] CAUSE_SURR     = 3'd5;
    localparam logic [2:0] CAUSE_EARLY    = 3'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    // One queued command: up to four bytes to emit, or a single report.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic [1:0]      kind;
        logic [2:0]      cause;
    } cmd_t;

endpackage

### rtl/json_string_unescape_utf8_core.sv
// JSON string unescaper with UTF-8 output. Throughput: one input byte per
// cycle while the queue is not full; a \u escape emits up to three bytes and
// a surrogate pair four, one per cycle from the output register while
// m_tready is high, with a four-entry command queue absorbing the bursts.
// Reset (rst_n low, asynchronous) returns to idle and empties the queue.
module json_string_unescape_utf8_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [0:0]  s_tuser,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte [7:0], error_cause [10:8], zero
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);
    import jsu_pkg::*;

    logic       push;
    cmd_t       push_cmd;
    logic       full;
    logic       head_valid;
    cmd_t       head_cmd;
    logic       pop;
    logic [7:0] out_byte;
    logic [2:0] out_cause;

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_end     (s_tuser[0]),
        .queue_full (full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    jsu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .out_kind   (m_tuser),
        .out_cause  (out_cause),
        .out_last   (m_tlast)
    );

    assign m_tdata = {5'd0, out_cause, out_byte};

endmodule

### rtl/jsu_front.sv
// Front end of the unescaper: accepts input bytes, tracks the string syntax
// and turns each byte into at most one queued command. Depends on jsu_pkg.
module jsu_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_end,
    input  logic          queue_full,
    output logic          push,
    output jsu_pkg::cmd_t push_cmd
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX,
        PH_LOWBS,
        PH_LOWU,
        PH_HEXLO
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] code_unit_reg, code_unit_next;
    logic [9:0]  high_bits_reg, high_bits_next;

    logic        accept;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] unit_new;
    logic [10:0] plane;
    logic        produce;
    cmd_t        cmd;

    function automatic cmd_t single(input logic [7:0] b, input logic [1:0] k,
                                    input logic [2:0] c);
        cmd_t r;
        r          = '0;
        r.bytes[0] = b;
        r.last_idx = 2'd0;
        r.kind     = k;
        r.cause    = c;
        return r;
    endfunction

    function automatic cmd_t utf8(input logic [20:0] cp);
        cmd_t r;
        r       = '0;
        r.kind  = KIND_DATA;
        r.cause = CAUSE_NONE;
        if (cp < 21'h80)
        begin
            r.bytes[0] = cp[7:0];
            r.last_idx = 2'd0;
        end
        else if (cp < 21'h800)
        begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.last_idx = 2'd1;
        end
        else if (cp < 21'h10000)
        begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.last_idx = 2'd2;
        end
        else
        begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.last_idx = 2'd3;
        end
        return r;
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = in_byte[3:0];
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            hex_val = in_byte[3:0];
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46))
            hex_val = in_byte[3:0] + 4'd9;
        else
            hex_ok = 1'b0;
    end

    assign unit_new = {code_unit_reg[11:0], hex_val};
    assign plane    = {1'b0, high_bits_reg} + 11'h040;

    always_comb
    begin
        phase_next     = phase_reg;
        hex_cnt_next   = hex_cnt_reg;
        code_unit_next = code_unit_reg;
        high_bits_next = high_bits_reg;
        produce        = 1'b0;
        cmd            = single(8'h00, KIND_ERROR, CAUSE_EARLY);

        if (in_end)
        begin
            produce = 1'b1;
            cmd     = single(8'h00, KIND_ERROR, CAUSE_EARLY);
        end
        else
        begin
            case (phase_reg)
                PH_BODY:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        produce = 1'b1;
                        cmd     = single(8'h00, KIND_DONE, CAUSE_NONE);
                    end
                    else if (in_byte < CH_SPACE)
                    begin
                        produce = 1'b1;
                        cmd     = single(8'h00, KIND_ERROR, CAUSE_CONTROL);
                    end
                    else if (in_byte == CH_BSL)
                        phase_next = PH_ESC;
                    else
                    begin
                        produce = 1'b1;
                        cmd     = single(in_byte, KIND_DATA, CAUSE_NONE);
                    end
                end
                PH_ESC:
                begin
                    produce    = 1'b1;
                    phase_next = PH_BODY;
                    case (in_byte)
                        CH_QUOTE: cmd = single(8'h22, KIND_DATA, CAUSE_NONE);
                        CH_BSL:   cmd = single(8'h5C, KIND_DATA, CAUSE_NONE);
                        CH_SLASH: cmd = single(8'h2F, KIND_DATA, CAUSE_NONE);
                        CH_B:     cmd = single(8'h08, KIND_DATA, CAUSE_NONE);
                        CH_F:     cmd = single(8'h0C, KIND_DATA, CAUSE_NONE);
                        CH_N:     cmd = single(8'h0A, KIND_DATA, CAUSE_NONE);
                        CH_R:     cmd = single(8'h0D, KIND_DATA, CAUSE_NONE);
                        CH_T:     cmd = single(8'h09, KIND_DATA, CAUSE_NONE);
                        CH_U:
                        begin
                            produce        = 1'b0;
                            phase_next     = PH_HEX;
                            hex_cnt_next   = 2'd0;
                            code_unit_next = 16'h0000;
                        end
                        default:  cmd = single(8'h00, KIND_ERROR, CAUSE_ESCAPE);
                    endcase
                end
                PH_HEX, PH_HEXLO:
                begin
                    if (!hex_ok)
                    begin
                        produce = 1'b1;
                        cmd     = single(8'h00, KIND_ERROR, CAUSE_HEX);
                    end
                    else if (hex_cnt_reg != 2'd3)
                    begin
                        hex_cnt_next   = hex_cnt_reg + 2'd1;
                        code_unit_next = unit_new;
                    end
                    else
                    begin
                        hex_cnt_next   = 2'd0;
                        code_unit_next = 16'h0000;
                        if (phase_reg == PH_HEX)
                        begin
                            if (unit_new[15:10] == SURR_HIGH_TAG)
                            begin
                                high_bits_next = unit_new[9:0];
                                phase_next     = PH_LOWBS;
                            end
                            else if (unit_new[15:10] == SURR_LOW_TAG)
                            begin
                                produce = 1'b1;
                                cmd     = single(8'h00, KIND_ERROR, CAUSE_SURR);
                            end
                            else
                            begin
                                produce    = 1'b1;
                                phase_next = PH_BODY;
                                cmd        = utf8({5'd0, unit_new});
                            end
                        end
                        else if (unit_new[15:10] != SURR_LOW_TAG)
                        begin
                            produce = 1'b1;
                            cmd     = single(8'h00, KIND_ERROR, CAUSE_SURR);
                        end
                        else
                        begin
                            produce        = 1'b1;
                            phase_next     = PH_BODY;
                            high_bits_next = 10'd0;
                            cmd            = utf8({plane, unit_new[9:0]});
                        end
                    end
                end
                PH_LOWBS:
                begin
                    if (in_byte != CH_BSL)
                    begin
                        produce = 1'b1;
                        cmd     = single(8'h00, KIND_ERROR, CAUSE_SURR);
                    end
                    else
                        phase_next = PH_LOWU;
                end
                PH_LOWU:
                begin
                    if (in_byte != CH_U)
                    begin
                        produce = 1'b1;
                        cmd     = single(8'h00, KIND_ERROR, CAUSE_SURR);
                    end
                    else
                    begin
                        phase_next     = PH_HEXLO;
                        hex_cnt_next   = 2'd0;
                        code_unit_next = 16'h0000;
                    end
                end
                default:
                begin
                    if (in_byte != CH_QUOTE)
                    begin
                        produce = 1'b1;
                        cmd     = single(8'h00, KIND_ERROR, CAUSE_NO_QUOTE);
                    end
                    else
                    begin
                        phase_next     = PH_BODY;
                        hex_cnt_next   = 2'd0;
                        code_unit_next = 16'h0000;
                        high_bits_next = 10'd0;
                    end
                end
            endcase
        end

        // A completion or an error always leaves the block idle and cleared.
        if (produce && cmd.kind != KIND_DATA)
        begin
            phase_next     = PH_IDLE;
            hex_cnt_next   = 2'd0;
            code_unit_next = 16'h0000;
            high_bits_next = 10'd0;
        end
    end

    assign push     = accept && produce;
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hex_cnt_reg   <= 2'd0;
            code_unit_reg <= 16'h0000;
            high_bits_reg <= 10'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            hex_cnt_reg   <= hex_cnt_next;
            code_unit_reg <= code_unit_next;
            high_bits_reg <= high_bits_next;
        end
    end

    a_hex_cnt_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
        hex_cnt_reg != 2'd0 |-> (phase_reg == PH_HEX || phase_reg == PH_HEXLO))
        else $error("hex digit count outside a hex escape");

    a_high_bits_pending: assert property (@(posedge clk) disable iff (!rst_n)
        high_bits_reg != 10'd0 |->
            (phase_reg == PH_LOWBS || phase_reg == PH_LOWU || phase_reg == PH_HEXLO))
        else $error("surrogate bits held with no low surrogate pending");

endmodule

### rtl/jsu_fifo.sv
// Short command queue between the front end and the back end.
// Depends on jsu_pkg for the command type and depth.
module jsu_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          head_valid,
    output jsu_pkg::cmd_t head_cmd,
    input  logic          pop
);
    import jsu_pkg::*;

    cmd_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full       = count_reg == FIFO_CW'(FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

### rtl/jsu_back.sv
// Back end of the unescaper: takes queued commands and sends their bytes
// one transfer at a time from an output register. Depends on jsu_pkg.
module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  jsu_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic [1:0]    out_kind,
    output logic [2:0]    out_cause,
    output logic          out_last
);
    import jsu_pkg::*;

    cmd_t       cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic       sent;
    logic       at_last;

    assign at_last = idx_reg == cur_reg.last_idx;
    assign sent    = valid_reg && out_ready;
    assign pop     = head_valid && (!valid_reg || (sent && at_last));

    always_comb
    begin
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (pop)
        begin
            cur_next   = head_cmd;
            idx_next   = 2'd0;
            valid_next = 1'b1;
        end
        else if (sent)
        begin
            if (at_last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = cur_reg.bytes[idx_reg];
    assign out_kind  = cur_reg.kind;
    assign out_cause = cur_reg.cause;
    assign out_last  = at_last;

    a_report_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && cur_reg.kind != KIND_DATA |-> at_last && idx_reg == 2'd0)
        else $error("completion or error report not a single transfer");

endmodule

### tb/tb_json_string_unescape_utf8_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for json_string_unescape_utf8_core: quoted JSON strings go in as byte
// transfers, and every decoded byte or report is checked against a predictor kept in a scoreboard.
// Depends on rtl/jsu_pkg.sv and rtl/json_string_unescape_utf8_core.sv.
module tb_json_string_unescape_utf8_core;
    import jsu_pkg::*;

    localparam int HOLD_CYCLES = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 64;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_BODY,
        SCAN_ESC,
        SCAN_HEX,
        SCAN_LOW_BSL,
        SCAN_LOW_U,
        SCAN_HEX_LOW
    } scan_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] cause;
        logic       last;
    } decoded_t;

    class unescape_scoreboard;
        scan_state_t state;
        logic [1:0]  digits;
        logic [15:0] unit;
        logic [9:0]  high_bits;
        decoded_t    decoded_q[$];
        int          n_inputs;
        int          n_results;
        int          n_errors;
        int          kind_count[3];
        logic [6:0]  causes_seen;

        function new();
            go_idle();
            n_inputs = 0;
            n_results = 0;
            n_errors = 0;
            causes_seen = '0;
            foreach (kind_count[i])
            begin
                kind_count[i] = 0;
            end
        endfunction

        function void go_idle();
            state = SCAN_IDLE;
            digits = 2'd0;
            unit = 16'h0000;
            high_bits = 10'd0;
        endfunction

        function int waiting();
            return decoded_q.size();
        endfunction

        function logic [4:0] hex_nibble(logic [7:0] b);
            logic [7:0] d;
            d = 8'h10;
            if (b >= 8'h30 && b <= 8'h39)
                d = b - 8'h30;
            else if (b >= 8'h61 && b <= 8'h66)
                d = b - 8'h61 + 8'd10;
            else if (b >= 8'h41 && b <= 8'h46)
                d = b - 8'h41 + 8'd10;
            return d[4:0];
        endfunction

        function void push(logic [7:0] b, logic [1:0] kind, logic [2:0] cause, logic last);
            decoded_t r;
            r.out_byte = b;
            r.kind = kind;
            r.cause = cause;
            r.last = last;
            decoded_q.push_back(r);
        endfunction

        function void report(logic [1:0] kind, logic [2:0] cause);
            go_idle();
            push(8'h00, kind, cause, 1'b1);
        endfunction

        function void escaped(logic [7:0] b);
            state = SCAN_BODY;
            push(b, KIND_DATA, CAUSE_NONE, 1'b1);
        endfunction

        function void push_utf8(logic [20:0] cp);
            if (cp < 21'h80)
            begin
                push(cp[7:0], KIND_DATA, CAUSE_NONE, 1'b1);
            end
            else if (cp < 21'h800)
            begin
                push({3'b110, cp[10:6]}, KIND_DATA, CAUSE_NONE, 1'b0);
                push({2'b10, cp[5:0]}, KIND_DATA, CAUSE_NONE, 1'b1);
            end
            else if (cp < 21'h10000)
            begin
                push({4'b1110, cp[15:12]}, KIND_DATA, CAUSE_NONE, 1'b0);
                push({2'b10, cp[11:6]}, KIND_DATA, CAUSE_NONE, 1'b0);
                push({2'b10, cp[5:0]}, KIND_DATA, CAUSE_NONE, 1'b1);
            end
            else
            begin
                push({5'b11110, cp[20:18]}, KIND_DATA, CAUSE_NONE, 1'b0);
                push({2'b10, cp[17:12]}, KIND_DATA, CAUSE_NONE, 1'b0);
                push({2'b10, cp[11:6]}, KIND_DATA, CAUSE_NONE, 1'b0);
                push({2'b10, cp[5:0]}, KIND_DATA, CAUSE_NONE, 1'b1);
            end
        endfunction

        function void note_input(logic [7:0] b, logic eoi);
            logic [4:0]  nib;
            logic [20:0] cp;
            n_inputs++;
            if (eoi)
            begin
                report(KIND_ERROR, CAUSE_EARLY);
                return;
            end
            case (state)
                SCAN_BODY:
                    if (b == CH_QUOTE)
                        report(KIND_DONE, CAUSE_NONE);
                    else if (b < CH_SPACE)
                        report(KIND_ERROR, CAUSE_CONTROL);
                    else if (b == CH_BSL)
                        state = SCAN_ESC;
                    else
                        push(b, KIND_DATA, CAUSE_NONE, 1'b1);
                SCAN_ESC:
                    case (b)
                        CH_QUOTE, CH_BSL, CH_SLASH: escaped(b);
                        CH_B: escaped(8'h08);
                        CH_F: escaped(8'h0C);
                        CH_N: escaped(8'h0A);
                        CH_R: escaped(8'h0D);
                        CH_T: escaped(8'h09);
                        CH_U:
                        begin
                            state = SCAN_HEX;
                            digits = 2'd0;
                            unit = 16'h0000;
                        end
                        default: report(KIND_ERROR, CAUSE_ESCAPE);
                    endcase
                SCAN_HEX, SCAN_HEX_LOW:
                begin
                    nib = hex_nibble(b);
                    if (nib[4])
                    begin
                        report(KIND_ERROR, CAUSE_HEX);
                    end
                    else
                    begin
                        unit = {unit[11:0], nib[3:0]};
                        if (digits != 2'd3)
                        begin
                            digits = digits + 2'd1;
                        end
                        else if (state == SCAN_HEX_LOW)
                        begin
                            if (unit[15:10] != SURR_LOW_TAG)
                            begin
                                report(KIND_ERROR, CAUSE_SURR);
                            end
                            else
                            begin
                                cp = 21'h10000 + {high_bits, unit[9:0]};
                                go_idle();
                                state = SCAN_BODY;
                                push_utf8(cp);
                            end
                        end
                        else if (unit[15:10] == SURR_HIGH_TAG)
                        begin
                            digits = 2'd0;
                            high_bits = unit[9:0];
                            unit = 16'h0000;
                            state = SCAN_LOW_BSL;
                        end
                        else if (unit[15:10] == SURR_LOW_TAG)
                        begin
                            report(KIND_ERROR, CAUSE_SURR);
                        end
                        else
                        begin
                            cp = {5'd0, unit};
                            digits = 2'd0;
                            unit = 16'h0000;
                            state = SCAN_BODY;
                            push_utf8(cp);
                        end
                    end
                end
                SCAN_LOW_BSL:
                    if (b != CH_BSL)
                        report(KIND_ERROR, CAUSE_SURR);
                    else
                        state = SCAN_LOW_U;
                SCAN_LOW_U:
                    if (b != CH_U)
                    begin
                        report(KIND_ERROR, CAUSE_SURR);
                    end
                    else
                    begin
                        state = SCAN_HEX_LOW;
                        digits = 2'd0;
                        unit = 16'h0000;
                    end
                default:
                    if (b != CH_QUOTE)
                    begin
                        report(KIND_ERROR, CAUSE_NO_QUOTE);
                    end
                    else
                    begin
                        go_idle();
                        state = SCAN_BODY;
                    end
            endcase
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                n_errors++;
                $display("%0t: result %0d: %s expected %0h, actual %0h",
                         $time, n_results, field, want, got);
            end
        endfunction

        function void check_result(logic [15:0] tdata, logic [1:0] tuser, logic tlast);
            decoded_t want;
            if (decoded_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result: expected none, actual tdata %04h kind %0d last %0b",
                         $time, tdata, tuser, tlast);
                return;
            end
            want = decoded_q.pop_front();
            n_results++;
            kind_count[want.kind]++;
            if (want.kind == KIND_ERROR)
                causes_seen[want.cause] = 1'b1;
            compare_field("out_byte", want.out_byte, tdata[7:0]);
            compare_field("error_cause", {5'd0, want.cause}, {5'd0, tdata[10:8]});
            compare_field("padding", 8'h00, {3'd0, tdata[15:11]});
            compare_field("kind", {6'd0, want.kind}, {6'd0, tuser});
            compare_field("last", {7'd0, want.last}, {7'd0, tlast});
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    logic [8:0]  byte_q[$];
    logic [7:0]  escape_letters[9] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R,
                                       CH_T, CH_U};

    unescape_scoreboard sb = new();

    json_string_unescape_utf8_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_input(s_tdata, s_tuser[0]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            m_tready <= 1'b0;
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("json_string_unescape_utf8_core regression: fail");
        $finish;
    end

    function automatic void put_byte(logic [7:0] b);
        byte_q.push_back({1'b0, b});
    endfunction

    function automatic void put_end();
        logic [7:0] junk;
        junk = 8'($urandom);
        byte_q.push_back({1'b1, junk});
    endfunction

    // Backslash, u and the leading ndig hex digits of u, in mixed case.
    function automatic void put_unit(logic [15:0] u, int ndig);
        logic [3:0] v;
        put_byte(CH_BSL);
        put_byte(CH_U);
        for (int i = 0; i < ndig; i++)
        begin
            v = u[15 - 4 * i -: 4];
            if (v < 4'd10)
                put_byte(8'h30 + v);
            else if ($urandom_range(1) == 0)
                put_byte(8'h61 + v - 8'd10);
            else
                put_byte(8'h41 + v - 8'd10);
        end
    endfunction

    function automatic void add_random_string();
        int          n;
        int          k;
        int          j;
        bit          taken;
        logic [7:0]  b;
        logic [9:0]  r;
        logic [15:0] u;
        b = 8'($urandom);
        k = $urandom_range(99);
        if (k < 3)
        begin
            put_end();
            return;
        end
        if (k < 7)
        begin
            while (b == CH_QUOTE)
                b = 8'($urandom);
            put_byte(b);
            return;
        end
        put_byte(CH_QUOTE);
        n = $urandom_range(8);
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            r = 10'($urandom);
            if (k < 35)
            begin
                b = 8'($urandom_range(8'h7F, 8'h20));
                while (b == CH_QUOTE || b == CH_BSL)
                    b = 8'($urandom_range(8'h7F, 8'h20));
                put_byte(b);
            end
            else if (k < 48)
            begin
                put_byte(8'($urandom_range(8'hFF, 8'h80)));
            end
            else if (k < 62)
            begin
                put_byte(CH_BSL);
                put_byte(escape_letters[4'($urandom_range(7))]);
            end
            else if (k < 78)
            begin
                case ($urandom_range(2))
                    0: u = 16'($urandom_range(16'h7F));
                    1: u = 16'($urandom_range(16'h7FF, 16'h80));
                    default:
                    begin
                        u = 16'($urandom_range(16'hFFFF, 16'h800));
                        while (u[15:11] == 5'b11011)
                            u = 16'($urandom_range(16'hFFFF, 16'h800));
                    end
                endcase
                put_unit(u, 4);
            end
            else if (k < 90)
            begin
                put_unit({SURR_HIGH_TAG, r}, 4);
                r = 10'($urandom);
                put_unit({SURR_LOW_TAG, r}, 4);
            end
            else
            begin
                case ($urandom_range(7))
                    0: put_byte(8'($urandom_range(31)));
                    1:
                    begin
                        put_byte(CH_BSL);
                        taken = 1'b1;
                        while (taken)
                        begin
                            b = 8'($urandom);
                            taken = 1'b0;
                            foreach (escape_letters[e])
                            begin
                                if (b == escape_letters[e])
                                    taken = 1'b1;
                            end
                        end
                        put_byte(b);
                    end
                    2:
                    begin
                        if ($urandom_range(1) == 1)
                            put_unit({SURR_HIGH_TAG, r}, 4);
                        put_unit(16'($urandom), $urandom_range(3));
                        while (sb.hex_nibble(b) < 5'd16)
                            b = 8'($urandom);
                        put_byte(b);
                    end
                    3: put_unit({SURR_LOW_TAG, r}, 4);
                    4:
                    begin
                        put_unit({SURR_HIGH_TAG, r}, 4);
                        while (b == CH_BSL)
                            b = 8'($urandom);
                        put_byte(b);
                    end
                    5:
                    begin
                        put_unit({SURR_HIGH_TAG, r}, 4);
                        put_byte(CH_BSL);
                        while (b == CH_U)
                            b = 8'($urandom);
                        put_byte(b);
                    end
                    6:
                    begin
                        put_unit({SURR_HIGH_TAG, r}, 4);
                        u = 16'($urandom);
                        while (u[15:10] == SURR_LOW_TAG)
                            u = 16'($urandom);
                        put_unit(u, 4);
                    end
                    default:
                    begin
                        case ($urandom_range(3))
                            1: put_byte(CH_BSL);
                            2: put_unit(16'($urandom), $urandom_range(3));
                            3:
                            begin
                                put_unit({SURR_HIGH_TAG, r}, 4);
                                j = $urandom_range(2);
                                if (j == 1)
                                    put_byte(CH_BSL);
                                else if (j == 2)
                                    put_unit(16'($urandom), $urandom_range(3));
                            end
                            default: ;
                        endcase
                        put_end();
                    end
                endcase
                return;
            end
        end
        if ($urandom_range(9) == 0)
            put_end();
        else
            put_byte(CH_QUOTE);
    endfunction

    task automatic send_item(input logic [8:0] item);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= item[7:0];
        s_tuser <= item[8];
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_all();
        while (byte_q.size() != 0)
            send_item(byte_q.pop_front());
    endtask

    initial
    begin : stimulus
        int src_pct[4];
        int snk_pct[4];
        src_pct = '{0, 80, 0, 21};
        snk_pct = '{0, 0, 80, 21};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        put_byte(8'hFF);
        byte_q.push_back({1'b1, 8'hFF});
        put_byte(CH_QUOTE);
        put_byte(8'h1F);
        put_byte(CH_QUOTE);
        put_byte(CH_BSL);
        put_byte(8'h71);
        put_byte(CH_QUOTE);
        put_unit(16'h0000, 4);
        put_unit(16'hD83D, 4);
        put_unit(16'hDE00, 4);
        put_byte(CH_SPACE);
        put_byte(CH_QUOTE);
        send_all();

        // The first phase also holds the receiver off so that the queue fills up.
        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct = src_pct[p];
            snk_stall_pct <= snk_pct[p];
            if (p == 0)
                hold_requests <= hold_requests + 1;
            while (byte_q.size() < PHASE_ITEMS)
                add_random_string();
            send_all();
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d input transfers and %0d results: %0d data bytes, %0d completions,",
                 sb.n_inputs, sb.n_results, sb.kind_count[KIND_DATA], sb.kind_count[KIND_DONE]);
        $display("%0d error reports (causes seen %b), under four idling mixes and a %0d-cycle hold-off.",
                 sb.kind_count[KIND_ERROR], sb.causes_seen, HOLD_CYCLES);
        if (sb.n_errors == 0 && sb.waiting() == 0)
            $display("json_string_unescape_utf8_core regression: pass");
        else
            $display("json_string_unescape_utf8_core regression: fail");
        $finish;
    end

endmodule
